// ===== rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// shared constants, types and helpers for the largest square search
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int MaxSide = 1024;
  localparam int ColW    = $clog2(MaxSide);
  localparam int SideW   = 11;
  localparam int PixW    = 8;
  localparam int PosW    = 10;

  localparam logic [PixW-1:0]  ValidByte = 8'd255;
  localparam logic [SideW-1:0] SideReset = 11'd800;

  typedef struct packed {
    logic [ColW-1:0] row;
    logic [ColW-1:0] col;
    logic            on_border;
    logic            final_pix;
  } pos_t;

  typedef struct packed {
    logic hit;
    pos_t pos;
  } stage_t;

  typedef struct packed {
    logic [SideW-1:0] side;
    logic [ColW-1:0]  row;
    logic [ColW-1:0]  col;
  } res_t;

  // last row or column index for a programmed side, clamped to the store depth
  function automatic logic [ColW-1:0] last_index(input logic [SideW-1:0] side);
    logic [ColW-1:0] idx;
    if (side == '0) begin
      idx = '0;
    end else if ({{(32-SideW){1'b0}}, side} > MaxSide) begin
      idx = ColW'(MaxSide - 1);
    end else begin
      idx = ColW'(side - 11'd1);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lsm_row_mem.sv =====
// ----------------------------------------------------------------------------
// lsm_row_mem
// side values of the row below, one write and one registered read a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_row_mem
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [ColW-1:0]  rd_addr_i,
  output logic [SideW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [ColW-1:0]  wr_addr_i,
  input  logic [SideW-1:0] wr_data_i
);

  logic [SideW-1:0] mem_q [MaxSide];
  logic [SideW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/lsm_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsm_scan_ctrl
// side register and reverse raster position counters
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_scan_ctrl
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SideW-1:0] cfg_wdata_i,
  input  logic             step_i,
  output pos_t             pos_o
);

  logic [SideW-1:0] side_q;
  logic [ColW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  last;

  assign last = last_index(side_q);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = last_index(cfg_wdata_i);
      col_d = last_index(cfg_wdata_i);
    end else if (step_i) begin
      if (col_q != '0) begin
        col_d = col_q - 1'b1;
      end else if (row_q != '0) begin
        row_d = row_q - 1'b1;
        col_d = last;
      end else begin
        row_d = last;
        col_d = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideReset;
      row_q  <= last_index(SideReset);
      col_q  <= last_index(SideReset);
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign pos_o.row       = row_q;
  assign pos_o.col       = col_q;
  assign pos_o.on_border = (row_q == last) || (col_q == last);
  assign pos_o.final_pix = (row_q == '0) && (col_q == '0);

endmodule

`default_nettype wire

// ===== rtl/lsm_best.sv =====
// ----------------------------------------------------------------------------
// lsm_best
// min-plus-one recurrence and tracking of the best square
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_best
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             adv_i,
  input  stage_t           stage_i,
  input  logic [SideW-1:0] below_i,
  output logic [SideW-1:0] side_o,
  output res_t             res_o
);

  logic [SideW-1:0] right_q;
  logic [SideW-1:0] diag_q;
  res_t             best_q;
  logic [SideW-1:0] m_ab;
  logic [SideW-1:0] m_abc;
  logic [SideW-1:0] s;

  always_comb begin
    m_ab  = (below_i < right_q) ? below_i : right_q;
    m_abc = (m_ab < diag_q) ? m_ab : diag_q;
    if (!stage_i.hit) begin
      s = '0;
    end else if (stage_i.pos.on_border) begin
      s = 11'd1;
    end else begin
      s = m_abc + 11'd1;
    end
  end

  always_comb begin
    res_o = best_q;
    if (s > best_q.side) begin
      res_o.side = s;
      res_o.row  = stage_i.pos.row;
      res_o.col  = stage_i.pos.col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      diag_q  <= '0;
      best_q  <= '0;
    end else if (restart_i || (adv_i && stage_i.pos.final_pix)) begin
      right_q <= '0;
      diag_q  <= '0;
      best_q  <= '0;
    end else if (adv_i) begin
      right_q <= s;
      diag_q  <= below_i;
      best_q  <= res_o;
    end
  end

  assign side_o = s;

endmodule

`default_nettype wire

// ===== rtl/largest_square_in_mask.sv =====
// ----------------------------------------------------------------------------
// largest_square_in_mask
// largest all-valid square in a square binary mask
//
// mask bytes arrive on the in channel (valid/ready) in reverse raster order,
// last row first and each row from its last column back to column 0; a byte
// of 255 is a valid pixel. cfg_we_i writes the side length and restarts the
// scan; write it only while no mask is in flight.
// after the word for pixel (0,0) one result word leaves on the out channel:
// best side, top row and left column, all zero when no pixel is valid.
// throughput is one pixel per cycle unless a final pixel waits on a stalled
// receiver, set by one read and one write of the row store per pixel; the
// final pixel and then its result word are registered before out_valid_o.
// reset sets the side to 800 and starts a fresh scan; the row store is not
// cleared, as every entry is written on the last row before it is read.
// a stalled receiver holds the result word; the next mask keeps flowing
// until its own final pixel, which then waits and drops in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_square_in_mask
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SideW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PixW-1:0]  mask_pixel_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SideW-1:0] best_side_o,
  output logic [PosW-1:0]  best_row_o,
  output logic [PosW-1:0]  best_col_o
);

  pos_t             pos;
  stage_t           s1_q;
  logic             s1_valid_q;
  logic             accept;
  logic             adv;
  logic             out_free;
  logic [SideW-1:0] below;
  logic [SideW-1:0] side;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = s1_valid_q && (!s1_q.pos.final_pix || out_free);
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  lsm_scan_ctrl u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (accept),
    .pos_o      (pos)
  );

  lsm_row_mem u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(pos.col),
    .rd_data_o(below),
    .wr_en_i  (adv),
    .wr_addr_i(s1_q.pos.col),
    .wr_data_i(side)
  );

  lsm_best u_best (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(cfg_we_i),
    .adv_i    (adv),
    .stage_i  (s1_q),
    .below_i  (below),
    .side_o   (side),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.hit <= (mask_pixel_i == ValidByte);
      s1_q.pos <= pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_q.pos.final_pix) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_q.pos.final_pix) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_side_o = out_q.side;
  assign best_row_o  = PosW'(out_q.row);
  assign best_col_o  = PosW'(out_q.col);

endmodule

`default_nettype wire

// ===== rtl/lsm_checker.sv =====
// ----------------------------------------------------------------------------
// lsm_checker
// port level checks on the largest square block
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_checker
  import lsm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [SideW-1:0] best_side_o,
  input logic [PosW-1:0]  best_row_o,
  input logic [PosW-1:0]  best_col_o
);

  // held result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_side_o)
      && $stable(best_row_o) && $stable(best_col_o))
    else $error("result word changed while stalled");

  // no square means a zero corner
  a_empty_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (best_side_o == '0) |-> (best_row_o == '0) && (best_col_o == '0))
    else $error("corner set without a square");

  a_side_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {{(32-SideW){1'b0}}, best_side_o} <= MaxSide)
    else $error("side beyond the store depth");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("block not idle in reset");

endmodule

bind largest_square_in_mask lsm_checker u_lsm_checker (.*);

`default_nettype wire
